FILE: rtl/hps_pkg.sv
// Shared types, constants and step table for the haptic pattern sequencer.
package hps_pkg;

    // Default sizes
    localparam int HPS_QUEUE_DEPTH   = 64;
    localparam int HPS_PATTERN_DEPTH = 16;

    // Field widths
    localparam int CODE_W   = 3;
    localparam int REPEAT_W = 8;
    localparam int DUR_W    = 10;
    localparam int STEP_W   = DUR_W + 1;
    localparam int QSTEPS_W = 7;
    localparam int TDATA_W  = 16;

    // Step durations in ms
    localparam logic [DUR_W-1:0] DUR_BUZZ_SHORT  = DUR_W'(100);
    localparam logic [DUR_W-1:0] DUR_BUZZ_MEDIUM = DUR_W'(250);
    localparam logic [DUR_W-1:0] DUR_BUZZ_LONG   = DUR_W'(500);
    localparam logic [DUR_W-1:0] DUR_PAUSE_SHORT = DUR_W'(80);
    localparam logic [DUR_W-1:0] DUR_PAUSE_MED   = DUR_W'(200);
    localparam logic [DUR_W-1:0] DUR_PAUSE_LONG  = DUR_W'(600);
    localparam logic [DUR_W-1:0] DUR_CLICK       = DUR_W'(40);
    localparam logic [DUR_W-1:0] DUR_NONE        = '0;
    localparam logic [DUR_W-1:0] ELAPSED_MAX     = '1;

    // Block codes
    typedef enum logic [CODE_W-1:0] {
        BLK_BUZZ_SHORT  = 3'd0,
        BLK_BUZZ_MEDIUM = 3'd1,
        BLK_BUZZ_LONG   = 3'd2,
        BLK_PAUSE_SHORT = 3'd3,
        BLK_PAUSE_MED   = 3'd4,
        BLK_PAUSE_LONG  = 3'd5,
        BLK_CLICK       = 3'd6,
        BLK_IGNORED     = 3'd7
    } t_block;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EXP_RD,
        S_EXP_PUSH,
        S_START_CHK,
        S_POP,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic exp_read;
        logic exp_push;
        logic exp_finish;
        logic pop_read;
        logic pop_load;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_last;
        logic running;
        logic tick_done;
        logic exp_done;
        logic q_nonempty;
        logic out_free;
    } t_status;

    // Map a block code to {motor bit, duration}; a zero duration means no step
    function automatic logic [STEP_W-1:0] step_entry(input logic [CODE_W-1:0] code);
        logic [STEP_W-1:0] e;
        unique case (t_block'(code))
            BLK_BUZZ_SHORT:  e = {1'b1, DUR_BUZZ_SHORT};
            BLK_BUZZ_MEDIUM: e = {1'b1, DUR_BUZZ_MEDIUM};
            BLK_BUZZ_LONG:   e = {1'b1, DUR_BUZZ_LONG};
            BLK_PAUSE_SHORT: e = {1'b0, DUR_PAUSE_SHORT};
            BLK_PAUSE_MED:   e = {1'b0, DUR_PAUSE_MED};
            BLK_PAUSE_LONG:  e = {1'b0, DUR_PAUSE_LONG};
            BLK_CLICK:       e = {1'b1, DUR_CLICK};
            default:         e = {1'b0, DUR_NONE};
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/hps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hps_ctrl.sv
// Sequencer controller: execute, then expand and start as needed, then result.
module hps_ctrl
    import hps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.is_tick) begin
                    n_state = (i_status.running && i_status.tick_done) ? S_START_CHK
                                                                       : S_RESULT;
                end else begin
                    n_state = i_status.is_last ? S_EXP_RD : S_RESULT;
                end
            end
            S_EXP_RD: begin
                n_state = i_status.exp_done ? S_START_CHK : S_EXP_PUSH;
            end
            S_EXP_PUSH: begin
                n_state = S_EXP_RD;
            end
            S_START_CHK: begin
                n_state = (!i_status.running && i_status.q_nonempty) ? S_POP : S_RESULT;
            end
            S_POP: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_EXP_RD: begin
                o_cmd.exp_finish = i_status.exp_done;
                o_cmd.exp_read   = !i_status.exp_done;
            end
            S_EXP_PUSH: begin
                o_cmd.exp_push = 1'b1;
            end
            S_START_CHK: begin
                o_cmd.pop_read = !i_status.running && i_status.q_nonempty;
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
            end
            S_RESULT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/hps_dp.sv
// Sequencer datapath: pattern buffer, step queue, step timer and result register.
module hps_dp
    import hps_pkg::*;
#(
    parameter int QUEUE_DEPTH   = HPS_QUEUE_DEPTH,
    parameter int PATTERN_DEPTH = HPS_PATTERN_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_req_type,
    input  logic [CODE_W-1:0]  i_block_id,
    input  logic               i_last_block,
    input  logic [REPEAT_W-1:0] i_repeat_count,
    input  logic               i_out_ready,
    output t_status            o_status,
    output logic               o_out_valid,
    output logic [TDATA_W-1:0] o_out_data
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PCW = $clog2(PATTERN_DEPTH + 1);
    localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);
    localparam logic [PCW-1:0] PFULL = PCW'(PATTERN_DEPTH);

    // Captured item
    logic                r_req, n_req;
    logic [CODE_W-1:0]   r_code, n_code;
    logic                r_last, n_last;
    logic [REPEAT_W-1:0] r_rep, n_rep;

    // Pattern and expansion state
    logic [PCW-1:0]      r_plen, n_plen;
    logic [PAW-1:0]      r_idx, n_idx;
    logic [REPEAT_W-1:0] r_pass, n_pass;
    logic                r_ovf, n_ovf;

    // Queue state
    logic [QAW-1:0]      r_head, n_head;
    logic [QAW-1:0]      r_tail, n_tail;
    logic [QCW-1:0]      r_count, n_count;

    // Step timer
    logic                r_running, n_running;
    logic                r_motor, n_motor;
    logic [DUR_W-1:0]    r_step_len, n_step_len;
    logic [DUR_W-1:0]    r_elapsed, n_elapsed;

    // Result register
    logic                r_out_valid, n_out_valid;
    logic [TDATA_W-1:0]  r_out_data, n_out_data;

    // Memory ports
    logic                pb_we;
    logic [CODE_W-1:0]   pb_rdata;
    logic                q_we;
    logic [STEP_W-1:0]   q_wdata;
    logic [STEP_W-1:0]   q_rdata;

    logic [DUR_W-1:0]    elapsed_inc;
    logic [STEP_W-1:0]   entry;
    logic                busy;

    hps_ram #(
        .WIDTH(CODE_W),
        .DEPTH(PATTERN_DEPTH),
        .AW   (PAW)
    ) u_pattern_ram (
        .i_clk  (i_clk),
        .i_we   (pb_we),
        .i_waddr(r_plen[PAW-1:0]),
        .i_wdata(r_code),
        .i_re   (i_cmd.exp_read),
        .i_raddr(r_idx),
        .o_rdata(pb_rdata)
    );

    hps_ram #(
        .WIDTH(STEP_W),
        .DEPTH(QUEUE_DEPTH),
        .AW   (QAW)
    ) u_queue_ram (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(r_tail),
        .i_wdata(q_wdata),
        .i_re   (i_cmd.pop_read),
        .i_raddr(r_head),
        .o_rdata(q_rdata)
    );

    // Saturating millisecond count of the running step
    assign elapsed_inc = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign entry       = step_entry(pb_rdata);
    assign busy        = r_running || (r_count != '0);

    // Status to controller
    always_comb begin
        o_status.is_tick    = (r_req == REQ_TICK);
        o_status.is_last    = r_last;
        o_status.running    = r_running;
        o_status.tick_done  = (elapsed_inc >= r_step_len);
        o_status.exp_done   = (r_pass == r_rep) || (r_plen == '0);
        o_status.q_nonempty = (r_count != '0);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Next values
    always_comb begin
        n_req       = r_req;
        n_code      = r_code;
        n_last      = r_last;
        n_rep       = r_rep;
        n_plen      = r_plen;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_ovf       = r_ovf;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_running   = r_running;
        n_motor     = r_motor;
        n_step_len  = r_step_len;
        n_elapsed   = r_elapsed;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        pb_we       = 1'b0;
        q_we        = 1'b0;
        q_wdata     = entry;

        // Take the beat
        if (i_cmd.capture) begin
            n_req  = i_req_type;
            n_code = i_block_id;
            n_last = i_last_block;
            n_rep  = i_repeat_count;
            n_ovf  = 1'b0;
        end

        // Store a block or count a tick
        if (i_cmd.exec) begin
            n_idx  = '0;
            n_pass = '0;
            if (r_req == REQ_LOAD) begin
                if (r_plen < PFULL) begin
                    pb_we  = 1'b1;
                    n_plen = r_plen + 1'b1;
                end
            end else if (r_running) begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= r_step_len) begin
                    n_motor   = 1'b0;
                    n_running = 1'b0;
                end
            end
        end

        // Push one expanded step, drop it when the queue is full
        if (i_cmd.exp_push) begin
            if (entry[DUR_W-1:0] != DUR_NONE) begin
                if (r_count == QFULL) begin
                    n_ovf = 1'b1;
                end else begin
                    q_we    = 1'b1;
                    n_tail  = (r_tail == QLAST) ? '0 : r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            if (PCW'(r_idx) + PCW'(1) == r_plen) begin
                n_idx  = '0;
                n_pass = r_pass + 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end

        // Empty the pattern after expansion
        if (i_cmd.exp_finish) begin
            n_plen = '0;
        end

        // Start the step at the queue head
        if (i_cmd.pop_load) begin
            n_motor    = q_rdata[DUR_W];
            n_step_len = q_rdata[DUR_W-1:0];
            n_elapsed  = '0;
            n_running  = 1'b1;
            n_head     = (r_head == QLAST) ? '0 : r_head + 1'b1;
            n_count    = r_count - 1'b1;
        end

        // Result register
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_out_data  = {(TDATA_W - QSTEPS_W - 3)'(0), QSTEPS_W'(r_count), r_ovf,
                           busy, r_motor};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_idx       <= '0;
            r_pass      <= '0;
            r_ovf       <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_motor     <= 1'b0;
            r_step_len  <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_plen      <= n_plen;
            r_idx       <= n_idx;
            r_pass      <= n_pass;
            r_ovf       <= n_ovf;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_running   <= n_running;
            r_motor     <= n_motor;
            r_step_len  <= n_step_len;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_code     <= n_code;
        r_last     <= n_last;
        r_rep      <= n_rep;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/haptic_pattern_sequencer_unit.sv
// Haptic pattern sequencer top level: stream ports, controller and datapath.
//
// Usage: the slave stream takes one request per beat. tuser is the request
// kind (0 load a pattern block, 1 one millisecond tick); tlast marks the
// final block of a pattern, which replays the buffered pattern repeat_count
// times into the step queue. Each request yields exactly one result beat on
// the master stream carrying the motor/LED level, busy, the overflow flag of
// that request and the number of queued steps.
// Flow: one request is in work at a time. A plain load or a tick passes the
// execute and result states; a tick that ends a step also passes the start
// check and, when a step is queued, the pop state. A last block adds one
// pattern buffer read and one queue push per stored block per replay (no write
// for a zero duration or a full queue), then closes the expansion and starts
// the first step if the timer is idle, before its result is loaded.
// Reset clears the counters, queue pointers and timer; the motor is off.
// While the receiver stalls, the result stays registered; the next request is
// taken and worked on, and its result waits until the register is free.
module haptic_pattern_sequencer_unit
    import hps_pkg::*;
#(
    parameter int QUEUE_DEPTH   = HPS_QUEUE_DEPTH,
    parameter int PATTERN_DEPTH = HPS_PATTERN_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,  // [2:0] block_id, [10:3] repeat_count
    input  logic               i_s_tuser,  // [0] req_type
    input  logic               i_s_tlast,  // last_block
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata   // [0] motor_on, [1] busy_res,
                                           // [2] queue_overflow, [9:3] queued_steps
);

    t_cmd    cmd;
    t_status status;

    hps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_tvalid),
        .i_status  (status),
        .o_in_ready(o_s_tready),
        .o_cmd     (cmd)
    );

    hps_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PATTERN_DEPTH(PATTERN_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_s_tuser),
        .i_block_id    (i_s_tdata[CODE_W-1:0]),
        .i_last_block  (i_s_tlast),
        .i_repeat_count(i_s_tdata[CODE_W+REPEAT_W-1:CODE_W]),
        .i_out_ready   (i_m_tready),
        .o_status      (status),
        .o_out_valid   (o_m_tvalid),
        .o_out_data    (o_m_tdata)
    );

endmodule

FILE: tb/sv/tb_haptic_pattern_sequencer_unit.sv
// Self-checking testbench for the haptic pattern sequencer: directed table plus random beats.
module tb_haptic_pattern_sequencer_unit
    import hps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH     = 64;
    localparam int PAT_DEPTH      = 16;
    localparam int RAND_PER_PHASE = 300;
    localparam int DRAIN_CYCLES   = 50;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int N_OPEN         = 23;
    localparam int N_ROWS         = 27;

    // One result beat, motor_on in the lowest bit
    typedef struct packed {
        logic [QSTEPS_W-1:0] queued;
        logic                ovf;
        logic                busy;
        logic                motor;
    } t_seq_result;

    // One row of the directed table; want is only used when pinned is set
    typedef struct packed {
        logic        req;
        t_block      code;
        logic        last;
        logic [7:0]  rep;
        bit          pinned;
        t_seq_result want;
    } t_dir_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata  = '0;  // [2:0] block_id, [10:3] repeat_count
    logic               i_s_tuser  = 1'b0; // [0] req_type
    logic               i_s_tlast  = 1'b0; // last_block
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;  // [0] motor_on, [1] busy_res, [2] queue_overflow,
                                    // [9:3] queued_steps

    haptic_pattern_sequencer_unit #(
        .QUEUE_DEPTH   (FIFO_DEPTH),
        .PATTERN_DEPTH (PAT_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Directed table: {queued, ovf, busy, motor} in want
    t_dir_row dir_rows [0:N_ROWS-1] = '{
        // tick while idle, then a load with no last mark
        '{REQ_TICK, BLK_BUZZ_LONG,   1'b1, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_CLICK,       1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        // fill the pattern buffer with skipped codes
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd255, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, BLK_IGNORED,     1'b0, 8'd0,   1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
        // buffer full: last block dropped, stored click replayed twice, first one starts
        '{REQ_LOAD, BLK_PAUSE_LONG,  1'b1, 8'd2,   1'b1, '{7'd1, 1'b0, 1'b1, 1'b1}},
        // zero repeat queues nothing
        '{REQ_LOAD, BLK_BUZZ_LONG,   1'b1, 8'd0,   1'b1, '{7'd1, 1'b0, 1'b1, 1'b1}},
        '{REQ_LOAD, BLK_BUZZ_MEDIUM, 1'b0, 8'd0,   1'b1, '{7'd1, 1'b0, 1'b1, 1'b1}},
        '{REQ_LOAD, BLK_PAUSE_SHORT, 1'b1, 8'd1,   1'b1, '{7'd3, 1'b0, 1'b1, 1'b1}},
        '{REQ_TICK, BLK_CLICK,       1'b0, 8'd0,   1'b0, '0},
        '{REQ_TICK, BLK_IGNORED,     1'b1, 8'd170, 1'b0, '0},
        // closing rows: maximum repeat overruns the step queue
        '{REQ_LOAD, BLK_BUZZ_LONG,   1'b0, 8'd0,   1'b0, '0},
        '{REQ_LOAD, BLK_IGNORED,     1'b1, 8'd255, 1'b0, '0},
        '{REQ_TICK, BLK_BUZZ_SHORT,  1'b0, 8'd85,  1'b0, '0},
        '{REQ_LOAD, BLK_CLICK,       1'b1, 8'd1,   1'b0, '0}
    };

    // Step entries per block code: {motor, duration in ms}; zero duration is no step
    logic [STEP_W-1:0] step_rom [8] = '{
        {1'b1, 10'd100}, {1'b1, 10'd250}, {1'b1, 10'd500},
        {1'b0, 10'd80},  {1'b0, 10'd200}, {1'b0, 10'd600},
        {1'b1, 10'd40},  {1'b0, 10'd0}
    };

    // Sequencer state mirrored by the predictor
    logic [CODE_W-1:0] pat_buf [PAT_DEPTH];
    int                pat_len;
    logic [STEP_W-1:0] step_fifo [FIFO_DEPTH];
    int                fifo_head, fifo_tail, fifo_count;
    bit                step_active, motor_level;
    int                step_ms, elapsed_ms;

    t_seq_result pending_results [$];
    bit          beat_pinned = 1'b0;
    t_seq_result beat_want   = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int blocks_left   = 0;
    bit pattern_broken = 1'b0;

    int cycle_count      = 0;
    int error_count      = 0;
    int results_seen     = 0;
    int loads_seen       = 0;
    int patterns_closed  = 0;
    int ticks_seen       = 0;
    int steps_finished   = 0;
    int overflow_results = 0;

    // Pop the oldest queued step into the timer
    function automatic void start_next_step();
        logic [STEP_W-1:0] st;
        if (fifo_count == 0) return;
        st          = step_fifo[fifo_head];
        fifo_head   = (fifo_head + 1) % FIFO_DEPTH;
        fifo_count--;
        motor_level = st[DUR_W];
        step_ms     = st[DUR_W-1:0];
        elapsed_ms  = 0;
        step_active = 1'b1;
    endfunction

    // Apply one accepted request to the mirrored state and return its result
    function automatic t_seq_result advance_sequencer(logic req, logic [CODE_W-1:0] code,
                                                      logic last, logic [7:0] rep);
        t_seq_result       r;
        logic [STEP_W-1:0] st;
        bit                dropped;
        dropped = 1'b0;
        if (req == REQ_LOAD) begin
            loads_seen++;
            if (pat_len < PAT_DEPTH) begin
                pat_buf[pat_len] = code;
                pat_len++;
            end
            if (last) begin
                patterns_closed++;
                for (int k = 0; k < rep; k++) begin
                    for (int j = 0; j < pat_len; j++) begin
                        st = step_rom[pat_buf[j]];
                        if (st[DUR_W-1:0] != 0) begin
                            if (fifo_count >= FIFO_DEPTH) begin
                                dropped = 1'b1;
                            end else begin
                                step_fifo[fifo_tail] = st;
                                fifo_tail = (fifo_tail + 1) % FIFO_DEPTH;
                                fifo_count++;
                            end
                        end
                    end
                end
                pat_len = 0;
                if (!step_active) start_next_step();
            end
        end else begin
            ticks_seen++;
            if (step_active) begin
                if (elapsed_ms < 1023) elapsed_ms++;
                if (elapsed_ms >= step_ms) begin
                    motor_level = 1'b0;
                    step_active = 1'b0;
                    steps_finished++;
                    start_next_step();
                end
            end
        end
        if (dropped) overflow_results++;
        r.motor  = motor_level;
        r.busy   = step_active || (fifo_count > 0);
        r.ovf    = dropped;
        r.queued = QSTEPS_W'(fifo_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d: %s got %0d want %0d", results_seen, what, got, want);
        error_count++;
    endtask

    // Drive one request beat; called and returning at a falling edge
    task automatic send_beat(logic req, t_block code, logic last, logic [7:0] rep,
                             bit pinned, t_seq_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid  <= 1'b1;
        i_s_tuser   <= req;
        i_s_tlast   <= last;
        i_s_tdata   <= TDATA_W'({rep, code});
        beat_pinned <= pinned;
        beat_want   <= want;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic walk_rows(int first, int stop);
        for (int i = first; i < stop; i++)
            send_beat(dir_rows[i].req, dir_rows[i].code, dir_rows[i].last,
                      dir_rows[i].rep, dir_rows[i].pinned, dir_rows[i].want);
    endtask

    // Mostly ticks; patterns start more often while the queue is short
    task automatic send_random_item();
        t_block     code;
        logic [7:0] rep;
        logic       last;
        int         pick;
        rep  = 8'($urandom_range(255));
        code = ($urandom_range(99) < 40) ? BLK_CLICK : t_block'(CODE_W'($urandom_range(7)));
        if (blocks_left == 0 && $urandom_range(99) < ((fifo_count < 4) ? 10 : 1)) begin
            blocks_left    = ($urandom_range(9) == 0) ? $urandom_range(18, 1)
                                                      : $urandom_range(3, 1);
            pattern_broken = ($urandom_range(9) == 0);
        end
        if (blocks_left > 0 && $urandom_range(99) < 80) begin
            blocks_left--;
            last = (blocks_left == 0) && !pattern_broken;
            if (last) begin
                pick = $urandom_range(99);
                rep  = (pick < 10) ? 8'd0 :
                       (pick < 95) ? 8'($urandom_range(3, 1)) : 8'($urandom_range(8, 4));
            end
            send_beat(REQ_LOAD, code, last, rep, 1'b0, '0);
        end else begin
            send_beat(REQ_TICK, code, 1'($urandom_range(1)), rep, 1'b0, '0);
        end
    endtask

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check results, then record accepted requests; bound the run
    always @(posedge i_clk) begin
        t_seq_result got;
        t_seq_result want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("tb_haptic_pattern_sequencer_unit: done, errors");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_seq_result'(o_m_tdata[9:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", o_m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.motor !== want.motor)
                    report_mismatch("motor_on", got.motor, want.motor);
                if (got.busy !== want.busy)
                    report_mismatch("busy_res", got.busy, want.busy);
                if (got.ovf !== want.ovf)
                    report_mismatch("queue_overflow", got.ovf, want.ovf);
                if (got.queued !== want.queued)
                    report_mismatch("queued_steps", got.queued, want.queued);
            end
            results_seen++;
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            want = advance_sequencer(i_s_tuser, i_s_tdata[CODE_W-1:0], i_s_tlast,
                                     i_s_tdata[CODE_W +: REPEAT_W]);
            pending_results.push_back(beat_pinned ? beat_want : want);
        end
    end

    // Stimulus and end of run
    initial begin
        pat_len     = 0;
        fifo_head   = 0;
        fifo_tail   = 0;
        fifo_count  = 0;
        step_active = 1'b0;
        motor_level = 1'b0;
        step_ms     = 0;
        elapsed_ms  = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 78;
        walk_rows(0, N_OPEN);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 78 : 0;
            recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 34 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++) send_random_item();
        end

        walk_rows(N_OPEN, N_ROWS);
        i_s_tvalid <= 1'b0;

        // Wait for every result, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d loads (%0d closing a pattern) and %0d ticks in %0d cycles",
                 loads_seen, patterns_closed, ticks_seen, cycle_count);
        $display("%0d steps ran out, %0d results flagged dropped steps, %0d mismatches",
                 steps_finished, overflow_results, error_count);
        if (error_count == 0) begin
            $display("tb_haptic_pattern_sequencer_unit: done, clean");
        end else begin
            $display("tb_haptic_pattern_sequencer_unit: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hps_pkg.sv
rtl/hps_ram.sv
rtl/hps_ctrl.sv
rtl/hps_dp.sv
rtl/haptic_pattern_sequencer_unit.sv
tb/sv/tb_haptic_pattern_sequencer_unit.sv
